### hdl/sdas_pkg.sv
// Shared types, constants and the digit arithmetic for the signed decimal adder/subtractor.
// No dependencies; compile first.
package sdas_pkg;

  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [4:0] DIGIT_BASE = 5'd10;

  typedef struct packed {
    logic [3:0] a_digit;
    logic [3:0] b_digit;
    logic       a_negative;
    logic       b_negative;
    logic       subtract;
    logic       last_pair;
  } in_word_t;

  typedef struct packed {
    logic [3:0] result_digit;
    logic       result_negative;
    logic       overflow;
    logic       last_digit;
  } out_word_t;

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_CMP_RD = 8'b0000_0010,
    S_CMP_EV = 8'b0000_0100,
    S_ARI_RD = 8'b0000_1000,
    S_ARI_EV = 8'b0001_0000,
    S_FINISH = 8'b0010_0000,
    S_EM_RD  = 8'b0100_0000,
    S_EM_LD  = 8'b1000_0000
  } state_t;

  // One decimal digit step: sum with carry, or difference with borrow.
  // Returns {carry_or_borrow_out, digit}.
  function automatic logic [4:0] digit_op(input logic sub, input logic [3:0] x,
                                          input logic [3:0] y, input logic cin);
    logic [4:0] s;
    logic [4:0] yy;
    logic [4:0] t;
    begin
      s  = {1'b0, x} + {1'b0, y} + {4'b0, cin};
      yy = {1'b0, y} + {4'b0, cin};
      t  = {1'b0, x} + DIGIT_BASE - yy;
      if (!sub) begin
        if (s >= DIGIT_BASE) digit_op = {1'b1, 4'(s - DIGIT_BASE)};
        else                 digit_op = {1'b0, s[3:0]};
      end else begin
        if ({1'b0, x} >= yy) digit_op = {1'b0, 4'({1'b0, x} - yy)};
        else                 digit_op = {1'b1, t[3:0]};
      end
    end
  endfunction

endpackage

### hdl/sdas_if.sv
// Valid/ready channel interfaces for digit pairs in and result digits out.
// Depends on sdas_pkg for the payload types.
interface sdas_in_if;
  import sdas_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdas_out_if;
  import sdas_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sdas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/signed_decimal_add_subtract_top.sv
// Top level of the sign-magnitude decimal adder/subtractor.
// Depends on sdas_pkg, sdas_if (channel interfaces) and sdas_ram.
//
// Usage:
//   in_ch carries one digit pair per word, least significant first; pad the
//   shorter operand with zeros. Signs and the subtract bit are taken from the
//   word marked last_pair, which starts the computation. Digits above nine
//   count as nine. Pairs beyond MAX_DIGITS are dropped and flagged (overflow).
//   out_ch returns the result digits most significant first, without leading
//   zeros; last_digit marks the units digit. A zero result is one digit 0,
//   positive.
// Sequencing:
//   After the last pair the block is busy with a magnitude compare from the
//   top digit down (only when the effective signs differ), a read and an
//   evaluate step per digit for the add/subtract, a finish step, and a read
//   and a load step per emitted digit. The add/subtract goes through one shared
//   digit unit; all reads use the registered read port of the digit stores.
//   in_ch.ready is low from the last pair until the final digit is in the
//   output register. A stall on out_ch holds the sequencer on the pending
//   digit; no digit is lost.
// Reset (rst, synchronous): empties the pair store and the output register.
module signed_decimal_add_subtract_top #(
  parameter int MAX_DIGITS = 32
) (
  input logic        clk,
  input logic        rst,
  sdas_in_if.sink    in_ch,
  sdas_out_if.source out_ch
);
  import sdas_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_t           state;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] hi_nz;
  logic [CNT_W-1:0] top;
  logic             dropped;
  logic             ovf_r;
  logic             a_neg_r;
  logic             neg_r;
  logic             is_sub;
  logic             a_ge;
  logic             carry;
  logic             any_nz;
  logic             out_valid;
  out_word_t        out_data;

  logic             in_fire;
  logic             full;
  logic             out_free;
  logic [3:0]       a_sat;
  logic [3:0]       b_sat;
  logic [7:0]       pair_rd;
  logic [3:0]       a_rd;
  logic [3:0]       b_rd;
  logic [3:0]       op_x;
  logic [3:0]       op_y;
  logic [4:0]       alu;
  logic             res_wr_en;
  logic [3:0]       res_wr_data;
  logic [3:0]       res_rd;

  assign in_ch.ready  = (state == S_LOAD);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign full         = (count >= CNT_W'(MAX_DIGITS));
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign a_sat = (in_ch.data.a_digit > DIGIT_MAX) ? DIGIT_MAX : in_ch.data.a_digit;
  assign b_sat = (in_ch.data.b_digit > DIGIT_MAX) ? DIGIT_MAX : in_ch.data.b_digit;

  sdas_ram #(.WIDTH(8), .DEPTH(MAX_DIGITS)) u_pairs (
    .clk     (clk),
    .wr_en   (in_fire && !full),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({a_sat, b_sat}),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (pair_rd)
  );

  assign a_rd = pair_rd[7:4];
  assign b_rd = pair_rd[3:0];

  // Larger magnitude is always the minuend.
  assign op_x = (is_sub && !a_ge) ? b_rd : a_rd;
  assign op_y = (is_sub && !a_ge) ? a_rd : b_rd;
  assign alu  = digit_op(is_sub, op_x, op_y, carry);

  assign res_wr_en   = (state == S_ARI_EV) || (state == S_FINISH);
  assign res_wr_data = (state == S_FINISH) ? {3'b000, carry} : alu[3:0];

  sdas_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS + 1)) u_result (
    .clk     (clk),
    .wr_en   (res_wr_en),
    .wr_addr (idx),
    .wr_data (res_wr_data),
    .rd_addr (idx),
    .rd_data (res_rd)
  );

  // Index of the most significant digit to emit.
  assign top = (carry && !is_sub) ? n_r : (any_nz ? hi_nz : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready && state != S_EM_LD) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (in_ch.data.last_pair) begin
              n_r     <= full ? count : count + CNT_W'(1);
              ovf_r   <= dropped || full;
              count   <= '0;
              dropped <= 1'b0;
              a_neg_r <= in_ch.data.a_negative;
              neg_r   <= in_ch.data.a_negative;
              is_sub  <= in_ch.data.a_negative ^ in_ch.data.b_negative ^ in_ch.data.subtract;
              carry   <= 1'b0;
              any_nz  <= 1'b0;
              hi_nz   <= '0;
              a_ge    <= 1'b1;
              if (in_ch.data.a_negative ^ in_ch.data.b_negative ^ in_ch.data.subtract) begin
                idx   <= full ? count - CNT_W'(1) : count;
                state <= S_CMP_RD;
              end else begin
                idx   <= '0;
                state <= S_ARI_RD;
              end
            end else if (!full) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_CMP_RD: state <= S_CMP_EV;
        S_CMP_EV: begin
          // Walk from the top digit down to the first difference.
          if (a_rd != b_rd) begin
            a_ge  <= (a_rd > b_rd);
            neg_r <= (a_rd > b_rd) ? a_neg_r : !a_neg_r;
            idx   <= '0;
            state <= S_ARI_RD;
          end else if (idx == '0) begin
            state <= S_ARI_RD;
          end else begin
            idx   <= idx - CNT_W'(1);
            state <= S_CMP_RD;
          end
        end
        S_ARI_RD: state <= S_ARI_EV;
        S_ARI_EV: begin
          carry <= alu[4];
          if (alu[3:0] != 4'd0) begin
            any_nz <= 1'b1;
            hi_nz  <= idx;
          end
          idx   <= idx + CNT_W'(1);
          state <= (idx == n_r - CNT_W'(1)) ? S_FINISH : S_ARI_RD;
        end
        S_FINISH: begin
          idx <= top;
          if (!(carry && !is_sub) && !any_nz) neg_r <= 1'b0;
          state <= S_EM_RD;
        end
        S_EM_RD: state <= S_EM_LD;
        S_EM_LD: begin
          // Hold here until the output register frees up.
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.result_digit    <= res_rd;
            out_data.result_negative <= neg_r;
            out_data.overflow        <= ovf_r;
            out_data.last_digit      <= (idx == '0);
            if (idx == '0) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx - CNT_W'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("pair count beyond store depth");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_LD && out_free && idx == '0) |=>
      (state == S_LOAD && out_valid && out_data.last_digit))
    else $error("final digit did not close the operation");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_digit <= DIGIT_MAX))
    else $error("emitted digit out of decimal range");

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (idx <= n_r))
    else $error("emission start beyond computed digits");

endmodule
